@@ hdl/tmt_pkg.sv @@
// ----------------------------------------------------------------------------
// Tabu move table package
// Field widths, request codes, controller states and the command bundle
// shared by the controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package tmt_pkg;

    // Widths of the port fields.
    localparam int REQ_W    = 2;
    localparam int INDEX_W  = 8;
    localparam int PROC_W   = 4;
    localparam int TENURE_W = 5;
    localparam int OCC_W    = 5;

    // Defaults for the top level parameters.
    localparam int ENTRIES_DEF   = 16;
    localparam int TASK_BITS_DEF = 8;
    localparam int PROC_BITS_DEF = 4;

    localparam logic [TENURE_W-1:0] TENURE_RESET = 5'd10;
    localparam logic [TENURE_W-1:0] TENURE_MAX   = 5'd16;
    localparam logic [TENURE_W-1:0] TENURE_MIN   = 5'd1;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_ADD   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_QUERY = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TICK  = 2'd2;

    // Move kinds.
    localparam logic KIND_SWAP   = 1'b0;
    localparam logic KIND_CHANGE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_COMMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture the accepted request
        logic eval;    // compare every slot and register the vectors
        logic commit;  // update the slots and load the result register
    } t_cmd;

endpackage

@@ hdl/tabu_move_table_top.sv @@
// ----------------------------------------------------------------------------
// Tabu move table, top level
// A table of forbidden search moves with a remaining tenure each: add,
// query and tick requests, one result per request.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake                 | Payload
//  ---------+---------------------------+-----------------------------------
//  request  | i_in_valid / o_in_stall   | req_type, move_kind, indices, procs
//  result   | o_out_valid / i_out_stall | is_tabu, overflow, occupancy
//  config   | i_cfg_wr_en               | i_cfg_wr_data (tenure)
//
//  Each request passes through three steps: capture, a compare of every slot in
//  parallel, and a commit that updates the slots and loads the result
//  register. The controller's sequence through these steps sets the rate.
//  Reset is synchronous and active low; it clears the slot valid bits, the
//  live count and the handshake state, and sets the tenure to ten.
//  A stalled result holds the commit step until the result register is
//  free, while the request side stays stalled for the whole sequence.
//
module tabu_move_table_top #(
    parameter int ENTRIES   = tmt_pkg::ENTRIES_DEF,
    parameter int TASK_BITS = tmt_pkg::TASK_BITS_DEF,
    parameter int PROC_BITS = tmt_pkg::PROC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [tmt_pkg::TENURE_W-1:0] i_cfg_wr_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [tmt_pkg::REQ_W-1:0]    i_req_type,
    input  logic                         i_move_kind,
    input  logic [tmt_pkg::INDEX_W-1:0]  i_first_index,
    input  logic [tmt_pkg::INDEX_W-1:0]  i_second_index,
    input  logic [tmt_pkg::PROC_W-1:0]   i_old_processor,
    input  logic [tmt_pkg::PROC_W-1:0]   i_new_processor,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_is_tabu,
    output logic                         o_overflow,
    output logic [tmt_pkg::OCC_W-1:0]    o_occupancy
);
    import tmt_pkg::*;

    // Commands from the controller to the datapath.
    t_cmd cmd;

    // The controller accepts a request only when idle, and only commits
    // once the previous result has been taken.
    tmt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    // The datapath holds the slots, the tenure register and the result.
    tmt_datapath #(
        .ENTRIES   (ENTRIES),
        .TASK_BITS (TASK_BITS),
        .PROC_BITS (PROC_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_req_type      (i_req_type),
        .i_move_kind     (i_move_kind),
        .i_first_index   (i_first_index),
        .i_second_index  (i_second_index),
        .i_old_processor (i_old_processor),
        .i_new_processor (i_new_processor),
        .o_is_tabu       (o_is_tabu),
        .o_overflow      (o_overflow),
        .o_occupancy     (o_occupancy)
    );

endmodule

@@ hdl/tmt_ctrl.sv @@
// ----------------------------------------------------------------------------
// Tabu move table controller
// Sequences one request through capture, compare and commit, and owns the
// handshake state of both channels.
// ----------------------------------------------------------------------------
module tmt_ctrl (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_stall,
    output logic         o_out_valid,
    input  logic         i_out_stall,
    output tmt_pkg::t_cmd o_cmd
);
    import tmt_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EVAL;
                end
            end
            ST_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = ST_COMMIT;
            end
            ST_COMMIT: begin
                // The result register must be empty or emptying this cycle.
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

@@ hdl/tmt_datapath.sv @@
// ----------------------------------------------------------------------------
// Tabu move table datapath
// Slot storage with one comparator per slot, the tenure register, the live
// entry count and the result register.
// ----------------------------------------------------------------------------
module tmt_datapath #(
    parameter int ENTRIES   = tmt_pkg::ENTRIES_DEF,
    parameter int TASK_BITS = tmt_pkg::TASK_BITS_DEF,
    parameter int PROC_BITS = tmt_pkg::PROC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tmt_pkg::t_cmd                i_cmd,
    input  logic                         i_cfg_wr_en,
    input  logic [tmt_pkg::TENURE_W-1:0] i_cfg_wr_data,
    input  logic [tmt_pkg::REQ_W-1:0]    i_req_type,
    input  logic                         i_move_kind,
    input  logic [tmt_pkg::INDEX_W-1:0]  i_first_index,
    input  logic [tmt_pkg::INDEX_W-1:0]  i_second_index,
    input  logic [tmt_pkg::PROC_W-1:0]   i_old_processor,
    input  logic [tmt_pkg::PROC_W-1:0]   i_new_processor,
    output logic                         o_is_tabu,
    output logic                         o_overflow,
    output logic [tmt_pkg::OCC_W-1:0]    o_occupancy
);
    import tmt_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    // Captured request.
    logic [REQ_W-1:0]     r_req;
    logic                 r_kind;
    logic [TASK_BITS-1:0] r_first, r_second;
    logic [PROC_BITS-1:0] r_oldp, r_newp;

    // Slot storage; only the valid bits are reset.
    logic [ENTRIES-1:0]   r_valid;
    logic                 r_slot_kind   [ENTRIES];
    logic [TASK_BITS-1:0] r_slot_first  [ENTRIES];
    logic [TASK_BITS-1:0] r_slot_second [ENTRIES];
    logic [PROC_BITS-1:0] r_slot_oldp   [ENTRIES];
    logic [PROC_BITS-1:0] r_slot_newp   [ENTRIES];
    logic [TENURE_W-1:0]  r_slot_left   [ENTRIES];

    logic [ENTRIES-1:0]   r_match, r_free, r_expire;
    logic [CW-1:0]        r_count, n_count;
    logic [TENURE_W-1:0]  r_tenure, tenure_eff;

    logic                 r_is_tabu, r_overflow;
    logic [OCC_W-1:0]     r_occupancy;

    logic [ENTRIES-1:0]   slot_match;
    logic                 found, has_free;
    logic [IW-1:0]        match_idx, free_idx;
    logic [CW-1:0]        n_expired;
    logic                 do_insert, do_refresh;

    // Tenure register and its effective value, clamped to one through sixteen.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tenure <= TENURE_RESET;
        end else if (i_cfg_wr_en) begin
            r_tenure <= i_cfg_wr_data;
        end
    end

    always_comb begin
        tenure_eff = r_tenure;
        if (r_tenure == '0) begin
            tenure_eff = TENURE_MIN;
        end else if (r_tenure > TENURE_MAX) begin
            tenure_eff = TENURE_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req    <= i_req_type;
            r_kind   <= i_move_kind;
            r_first  <= TASK_BITS'(i_first_index);
            r_second <= TASK_BITS'(i_second_index);
            r_oldp   <= PROC_BITS'(i_old_processor);
            r_newp   <= PROC_BITS'(i_new_processor);
        end
    end

    // One comparator per slot. Swaps match in either order.
    always_comb begin
        for (int s = 0; s < ENTRIES; s++) begin
            if (!r_valid[s] || (r_slot_kind[s] != r_kind)) begin
                slot_match[s] = 1'b0;
            end else if (r_kind == KIND_SWAP) begin
                slot_match[s] =
                    ((r_slot_first[s] == r_first) && (r_slot_second[s] == r_second)) ||
                    ((r_slot_first[s] == r_second) && (r_slot_second[s] == r_first));
            end else begin
                slot_match[s] = (r_slot_first[s] == r_first) &&
                                (r_slot_oldp[s] == r_oldp) &&
                                (r_slot_newp[s] == r_newp) &&
                                (r_slot_left[s] != '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_match <= slot_match;
            r_free  <= ~r_valid;
            for (int s = 0; s < ENTRIES; s++) begin
                r_expire[s] <= r_valid[s] && (r_slot_left[s] <= TENURE_W'(1));
            end
        end
    end

    // Lowest matching slot and lowest free slot.
    always_comb begin
        found     = 1'b0;
        has_free  = 1'b0;
        match_idx = '0;
        free_idx  = '0;
        for (int s = 0; s < ENTRIES; s++) begin
            if (!found && r_match[s]) begin
                found     = 1'b1;
                match_idx = IW'(s);
            end
            if (!has_free && r_free[s]) begin
                has_free = 1'b1;
                free_idx = IW'(s);
            end
        end
    end

    always_comb begin
        n_expired = '0;
        for (int s = 0; s < ENTRIES; s++) begin
            n_expired = n_expired + CW'(r_expire[s]);
        end
    end

    assign do_refresh = (r_req == REQ_ADD) && found;
    assign do_insert  = (r_req == REQ_ADD) && !found && has_free;

    always_comb begin
        n_count = r_count;
        if (do_insert) begin
            n_count = r_count + CW'(1);
        end else if (r_req == REQ_TICK) begin
            n_count = r_count - n_expired;
        end
    end

    // Valid bits and live count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
        end else if (i_cmd.commit) begin
            r_count <= n_count;
            for (int s = 0; s < ENTRIES; s++) begin
                if (do_insert && (free_idx == IW'(s))) begin
                    r_valid[s] <= 1'b1;
                end else if ((r_req == REQ_TICK) && r_expire[s]) begin
                    r_valid[s] <= 1'b0;
                end
            end
        end
    end

    // Slot payload and remaining tenure.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            for (int s = 0; s < ENTRIES; s++) begin
                if (do_insert && (free_idx == IW'(s))) begin
                    r_slot_kind[s]   <= r_kind;
                    r_slot_first[s]  <= r_first;
                    r_slot_second[s] <= r_second;
                    r_slot_oldp[s]   <= r_oldp;
                    r_slot_newp[s]   <= r_newp;
                    r_slot_left[s]   <= tenure_eff;
                end else if (do_refresh && (match_idx == IW'(s))) begin
                    r_slot_left[s]   <= tenure_eff;
                end else if ((r_req == REQ_TICK) && r_valid[s]) begin
                    if (r_expire[s]) begin
                        r_slot_left[s] <= '0;
                    end else begin
                        r_slot_left[s] <= r_slot_left[s] - TENURE_W'(1);
                    end
                end
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_is_tabu   <= (r_req == REQ_QUERY) && found;
            r_overflow  <= (r_req == REQ_ADD) && !found && !has_free;
            r_occupancy <= OCC_W'(n_count);
        end
    end

    assign o_is_tabu   = r_is_tabu;
    assign o_overflow  = r_overflow;
    assign o_occupancy = r_occupancy;

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tabu move table testbench
// Drives add, query, tick and unused requests into the move table and
// predicts every result from a private copy of the table and its tenure
// register. The results are checked field by field, in order, while both
// handshakes idle at random and the tenure is set to values from across its range.
// ----------------------------------------------------------------------------
module testbench;

    import tmt_pkg::*;

    localparam int SLOTS          = ENTRIES_DEF;
    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 6;
    // Three steps per request plus some margin before a register write.
    localparam int SETTLE_CYCLES  = 8;
    localparam int PHASES         = 9;
    localparam int PHASE_REQUESTS = 186;
    localparam int HISTORY_DEPTH  = 32;
    // Bound on the run, after which the bench reports a failure.
    localparam int TIMEOUT_CYCLES = 600000;

    // The one request code that the block leaves unused.
    localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;

    // One request as it crosses the request channel.
    typedef struct packed {
        logic [REQ_W-1:0]   req;
        logic               kind;
        logic [INDEX_W-1:0] first;
        logic [INDEX_W-1:0] second;
        logic [PROC_W-1:0]  old_proc;
        logic [PROC_W-1:0]  new_proc;
    } t_request;

    localparam int REQUEST_BITS = $bits(t_request);

    // The answer that the block returns for each request.
    typedef struct packed {
        logic             is_tabu;
        logic             overflow;
        logic [OCC_W-1:0] occupancy;
    } t_answer;

    logic                clk;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [TENURE_W-1:0] cfg_wr_data;
    logic                in_valid;
    logic                in_stall;
    logic [REQ_W-1:0]    req_type;
    logic                move_kind;
    logic [INDEX_W-1:0]  first_index;
    logic [INDEX_W-1:0]  second_index;
    logic [PROC_W-1:0]   old_processor;
    logic [PROC_W-1:0]   new_processor;
    logic                out_valid;
    logic                out_stall;
    logic                is_tabu;
    logic                overflow;
    logic [OCC_W-1:0]    occupancy;

    tabu_move_table_top u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_req_type      (req_type),
        .i_move_kind     (move_kind),
        .i_first_index   (first_index),
        .i_second_index  (second_index),
        .i_old_processor (old_processor),
        .i_new_processor (new_processor),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_is_tabu       (is_tabu),
        .o_overflow      (overflow),
        .o_occupancy     (occupancy)
    );

    // ------------------------------------------------------------------------
    // Private copy of the move table. The fields of a slot are only looked at
    // while its live bit is set, exactly as in the block itself.
    // ------------------------------------------------------------------------
    logic                tbl_live   [SLOTS];
    logic                tbl_kind   [SLOTS];
    logic [INDEX_W-1:0]  tbl_first  [SLOTS];
    logic [INDEX_W-1:0]  tbl_second [SLOTS];
    logic [PROC_W-1:0]   tbl_old    [SLOTS];
    logic [PROC_W-1:0]   tbl_new    [SLOTS];
    logic [TENURE_W-1:0] tbl_left   [SLOTS];
    logic [TENURE_W-1:0] tenure_reg;

    // Answers predicted for accepted requests, oldest first.
    t_answer  awaited_answers [$];
    // Moves added recently, reused so that queries and re-adds find matches.
    t_request recent_moves [$];

    int tx_idle_pct;
    int rx_stall_pct;
    int mismatches;
    int requests_sent;
    int answers_checked;
    int predicted_hits;
    int predicted_overflows;
    int settings_used;

    // A swap matches in either index order and ignores the processors; a
    // change matches on task and both processors and ignores second_index.
    function automatic bit holds_move(int s, t_request r);
        if (!tbl_live[s] || tbl_kind[s] != r.kind)
            return 1'b0;
        if (r.kind == KIND_SWAP)
            return (tbl_first[s] == r.first && tbl_second[s] == r.second) ||
                   (tbl_first[s] == r.second && tbl_second[s] == r.first);
        return tbl_first[s] == r.first && tbl_old[s] == r.old_proc &&
               tbl_new[s] == r.new_proc;
    endfunction

    function automatic int live_entries();
        int n;
        n = 0;
        for (int s = 0; s < SLOTS; s++)
            if (tbl_live[s])
                n++;
        return n;
    endfunction

    // Applies one accepted request to the private table and returns the
    // answer that the block must give for it.
    function automatic t_answer tabu_table_update(t_request r);
        t_answer             a;
        logic [TENURE_W-1:0] t;
        int                  found;
        int                  free_slot;
        a         = '0;
        found     = -1;
        free_slot = -1;
        // A register value of zero behaves as one, anything above sixteen
        // as sixteen.
        t = tenure_reg;
        if (t < TENURE_MIN)
            t = TENURE_MIN;
        if (t > TENURE_MAX)
            t = TENURE_MAX;
        case (r.req)
            REQ_ADD: begin
                for (int s = 0; s < SLOTS; s++) begin
                    if (found < 0 && holds_move(s, r))
                        found = s;
                    if (free_slot < 0 && !tbl_live[s])
                        free_slot = s;
                end
                if (found >= 0) begin
                    tbl_left[found] = t;
                end else if (free_slot >= 0) begin
                    tbl_live[free_slot]   = 1'b1;
                    tbl_kind[free_slot]   = r.kind;
                    tbl_first[free_slot]  = r.first;
                    tbl_second[free_slot] = r.second;
                    tbl_old[free_slot]    = r.old_proc;
                    tbl_new[free_slot]    = r.new_proc;
                    tbl_left[free_slot]   = t;
                end else begin
                    a.overflow = 1'b1;
                end
            end
            REQ_QUERY: begin
                for (int s = 0; s < SLOTS; s++)
                    if (holds_move(s, r) && tbl_left[s] != '0)
                        a.is_tabu = 1'b1;
            end
            REQ_TICK: begin
                for (int s = 0; s < SLOTS; s++) begin
                    if (tbl_live[s]) begin
                        if (tbl_left[s] <= 1) begin
                            tbl_left[s] = '0;
                            tbl_live[s] = 1'b0;
                        end else begin
                            tbl_left[s] = tbl_left[s] - 1'b1;
                        end
                    end
                end
            end
            default: begin
                // The unused code leaves the table alone.
            end
        endcase
        a.occupancy = OCC_W'(live_entries());
        return a;
    endfunction

    function automatic t_request make_request(logic [REQ_W-1:0] req, logic kind,
                                              int first, int second,
                                              int old_proc, int new_proc);
        t_request r;
        r.req      = req;
        r.kind     = kind;
        r.first    = INDEX_W'(first);
        r.second   = INDEX_W'(second);
        r.old_proc = PROC_W'(old_proc);
        r.new_proc = PROC_W'(new_proc);
        return r;
    endfunction

    // Builds one random request. Many adds and most queries are well-formed
    // search traffic: they revisit recent moves, with the fields that a
    // match ignores scrambled and now and then a significant bit flipped.
    // The rest are fresh moves, drawn either from a narrow range, so that
    // they collide, or from the full range.
    function automatic t_request random_request(int tick_pct);
        t_request r;
        int       roll;
        int       add_limit;
        int       reuse_pct;
        r         = t_request'(REQUEST_BITS'($urandom));
        roll      = $urandom_range(99);
        add_limit = 4 + tick_pct + (96 - tick_pct) * 55 / 100;
        if (roll < 4) begin
            r.req = REQ_SPARE;
            return r;
        end
        if (roll < 4 + tick_pct) begin
            r.req = REQ_TICK;
            return r;
        end
        r.req     = (roll < add_limit) ? REQ_ADD : REQ_QUERY;
        reuse_pct = (r.req == REQ_ADD) ? 45 : 65;
        if (recent_moves.size() != 0 && $urandom_range(99) < reuse_pct) begin
            r      = recent_moves[$urandom_range(recent_moves.size() - 1)];
            r.req  = (roll < add_limit) ? REQ_ADD : REQ_QUERY;
            if (r.kind == KIND_SWAP) begin
                if ($urandom_range(1))
                    {r.first, r.second} = {r.second, r.first};
                r.old_proc = PROC_W'($urandom);
                r.new_proc = PROC_W'($urandom);
            end else begin
                r.second = INDEX_W'($urandom);
            end
            if ($urandom_range(5) == 0)
                r.first = r.first ^ (INDEX_W'(1) << $urandom_range(INDEX_W - 1));
        end else if ($urandom_range(1)) begin
            r.first    = INDEX_W'($urandom_range(7));
            r.second   = INDEX_W'($urandom_range(7));
            r.old_proc = PROC_W'($urandom_range(3));
            r.new_proc = PROC_W'($urandom_range(3));
        end
        if (r.req == REQ_ADD) begin
            recent_moves = {recent_moves, r};
            if (recent_moves.size() > HISTORY_DEPTH)
                void'(recent_moves.pop_front());
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Request side. Every task here is entered just after a rising edge, so
    // the nonblocking updates below land cleanly away from any clock edge.
    // ------------------------------------------------------------------------
    task automatic issue_request(t_request r);
        t_answer answer;
        int      gap;
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            gap = $urandom_range(3, 1);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        req_type      <= r.req;
        move_kind     <= r.kind;
        first_index   <= r.first;
        second_index  <= r.second;
        old_processor <= r.old_proc;
        new_processor <= r.new_proc;
        // The request is taken at the first edge that finds the stall low.
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        answer = tabu_table_update(r);
        awaited_answers = {awaited_answers, answer};
        requests_sent++;
        predicted_hits      += answer.is_tabu;
        predicted_overflows += answer.overflow;
    endtask

    // Holds the request side back until every answer is in, then lets the
    // block finish its three steps before anything else happens.
    task automatic wait_for_answers();
        in_valid <= 1'b0;
        while (awaited_answers.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // The tenure is only ever written while the block is idle.
    task automatic set_tenure(logic [TENURE_W-1:0] value);
        wait_for_answers();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        tenure_reg = value;
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    // ------------------------------------------------------------------------
    // Result side: a random stall, and an in-order check of every answer.
    // ------------------------------------------------------------------------
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < rx_stall_pct);

    task automatic compare_field(string field, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk) begin : answer_check
        t_answer want;
        if (rst_n && out_valid && !out_stall) begin
            if (awaited_answers.size() == 0) begin
                $error("result arrived with no request outstanding");
                mismatches++;
            end else begin
                want = awaited_answers.pop_front();
                compare_field("is_tabu", 8'(want.is_tabu), 8'(is_tabu));
                compare_field("overflow", 8'(want.overflow), 8'(overflow));
                compare_field("occupancy", 8'(want.occupancy), 8'(occupancy));
                answers_checked++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Swap moves in both index orders, change moves, the fields that a match
    // ignores, the extremes of each field, a refresh and the unused code.
    task automatic test_move_matching();
        issue_request(make_request(REQ_ADD, KIND_SWAP, 0, 255, 0, 0));
        issue_request(make_request(REQ_QUERY, KIND_SWAP, 255, 0, 15, 15));
        issue_request(make_request(REQ_QUERY, KIND_CHANGE, 0, 255, 0, 0));
        issue_request(make_request(REQ_ADD, KIND_CHANGE, 255, 0, 0, 15));
        issue_request(make_request(REQ_QUERY, KIND_CHANGE, 255, 255, 0, 15));
        issue_request(make_request(REQ_QUERY, KIND_CHANGE, 255, 0, 15, 0));
        issue_request(make_request(REQ_ADD, KIND_SWAP, 255, 0, 15, 15));
        issue_request(make_request(REQ_SPARE, KIND_CHANGE, 255, 255, 15, 15));
        issue_request(make_request(REQ_QUERY, KIND_SWAP, 0, 254, 0, 0));
        issue_request(make_request(REQ_TICK, KIND_SWAP, 0, 0, 0, 0));
    endtask

    // A tenure of zero behaves as one: the move is gone after one tick.
    task automatic test_tenure_floor();
        set_tenure('0);
        issue_request(make_request(REQ_ADD, KIND_SWAP, 1, 2, 3, 4));
        issue_request(make_request(REQ_QUERY, KIND_SWAP, 2, 1, 0, 0));
        issue_request(make_request(REQ_TICK, KIND_CHANGE, 0, 0, 0, 0));
        issue_request(make_request(REQ_QUERY, KIND_SWAP, 1, 2, 3, 4));
    endtask

    // Fills all sixteen slots, then adds a new move, which is dropped, and
    // an existing one, which is refreshed without an overflow.
    task automatic test_table_overflow();
        while (live_entries() != 0)
            issue_request(make_request(REQ_TICK, KIND_SWAP, 0, 0, 0, 0));
        for (int i = 0; i < SLOTS; i++)
            issue_request(make_request(REQ_ADD, KIND_CHANGE, i * 17, 0, i, 15 - i));
        issue_request(make_request(REQ_ADD, KIND_CHANGE, 1, 0, 0, 0));
        issue_request(make_request(REQ_ADD, KIND_CHANGE, 0, 99, 0, 15));
        issue_request(make_request(REQ_QUERY, KIND_CHANGE, 255, 0, 15, 0));
        issue_request(make_request(REQ_TICK, KIND_SWAP, 0, 0, 0, 0));
    endtask

    // Random search traffic over nine phases. Each idling pattern runs for
    // three phases, each phase with its own tenure (both extremes and the
    // out-of-range values among them) and its own tick rate, so that the
    // table sometimes drains and sometimes runs full.
    task automatic test_random_traffic();
        logic [TENURE_W-1:0] phase_tenure [PHASES];
        int                  tick_pct;
        phase_tenure = '{5'd10, 5'd1, 5'd16, 5'd31, 5'd0, 5'd3, 5'd17, 5'd7, 5'd2};
        for (int p = 0; p < PHASES; p++) begin
            set_tenure(phase_tenure[p]);
            case (p / 3)
                0: begin
                    tx_idle_pct  = 12;
                    rx_stall_pct = 88;
                end
                1: begin
                    tx_idle_pct  = 88;
                    rx_stall_pct = 12;
                end
                default: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
            endcase
            tick_pct = (p % 3 == 0) ? 4 : (p % 3 == 1) ? 15 : 30;
            for (int n = 0; n < PHASE_REQUESTS; n++) begin
                // Halfway through, the request side waits for every answer.
                if (n == PHASE_REQUESTS / 2)
                    wait_for_answers();
                issue_request(random_request(tick_pct));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Clock, reset and the test sequence.
    // ------------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("Timed out with %0d answers outstanding.", awaited_answers.size());
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        rst_n         <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= '0;
        in_valid      <= 1'b0;
        req_type      <= REQ_ADD;
        move_kind     <= KIND_SWAP;
        first_index   <= '0;
        second_index  <= '0;
        old_processor <= '0;
        new_processor <= '0;
        // Directed tests run under the first idling pattern.
        tx_idle_pct         = 12;
        rx_stall_pct        = 88;
        mismatches          = 0;
        requests_sent       = 0;
        answers_checked     = 0;
        predicted_hits      = 0;
        predicted_overflows = 0;
        settings_used       = 0;
        // Reset clears the live bits and loads the default tenure; the other
        // slot fields are left as they are and never read.
        tenure_reg = TENURE_RESET;
        for (int s = 0; s < SLOTS; s++) begin
            tbl_live[s]   = 1'b0;
            tbl_kind[s]   = KIND_SWAP;
            tbl_first[s]  = '0;
            tbl_second[s] = '0;
            tbl_old[s]    = '0;
            tbl_new[s]    = '0;
            tbl_left[s]   = '0;
        end
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_move_matching();
        test_tenure_floor();
        test_table_overflow();
        test_random_traffic();
        wait_for_answers();

        $display("Sent %0d requests under %0d tenure settings and three idling patterns.",
                 requests_sent, settings_used);
        $display("Checked %0d answers (%0d tabu hits, %0d overflows), %0d mismatches.",
                 answers_checked, predicted_hits, predicted_overflows, mismatches);
        if (mismatches == 0 && awaited_answers.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ files.f @@
hdl/tmt_pkg.sv
hdl/tmt_ctrl.sv
hdl/tmt_datapath.sv
hdl/tabu_move_table_top.sv
dv/testbench.sv
